@@ src/ctk_pkg.sv @@
`default_nettype none

package ctk_pkg;

   localparam int KEYS        = 2;
   localparam int KEY_AW      = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int CAL_SAMPLES = 240;

   localparam int FILT_W = 13;
   localparam int CAL_W  = 14;
   localparam int ACC_W  = 21;
   localparam int CNT_W  = 8;
   localparam int Q_W    = 12;

   localparam int ALPHA_W   = 7;
   localparam int ALPHA_MAX = 100;

   // divide by 100: magnitude below 2^19, reciprocal exact over that range
   localparam int FILT_MAG_W   = 19;
   localparam int FILT_SHIFT   = 26;
   localparam int FILT_RECIP   = ((2 ** FILT_SHIFT) + ALPHA_MAX - 1) / ALPHA_MAX;
   localparam int FILT_RECIP_W = $clog2(FILT_RECIP + 1);
   localparam int FILT_PROD_W  = FILT_MAG_W + FILT_RECIP_W;

   // divide by the calibration length
   localparam int CAL_MAG_W   = 20;
   localparam int CAL_SHIFT   = 28;
   localparam int CAL_RECIP   = ((2 ** CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
   localparam int CAL_RECIP_W = $clog2(CAL_RECIP + 1);
   localparam int CAL_PROD_W  = CAL_MAG_W + CAL_RECIP_W;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TIME = 3'd4;

   localparam logic [6:0]  ALPHA_RST     = 7'd70;
   localparam logic [9:0]  THRESHOLD_RST = 10'd20;
   localparam logic [31:0] SHORT_MIN_RST = 32'd1;
   localparam logic [31:0] SHORT_MAX_RST = 32'd20;
   localparam logic [31:0] LONG_TIME_RST = 32'd40;

   typedef enum logic [1:0] {
      OP_MEASURE = 2'd0,
      OP_WARMUP  = 2'd1,
      OP_ACCUM   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_HELD    = 2'd2,
      EV_RELEASE = 2'd3
   } ev_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [9:0]         threshold;
      logic [31:0]        short_min;
      logic [31:0]        short_max;
      logic [31:0]        long_time;
   } cfg_type;

   typedef struct packed {
      logic signed [FILT_W-1:0] filt;
      logic signed [CAL_W-1:0]  cal;
      logic                     last;
      logic [31:0]              start;
      logic [31:0]              held;
      logic                     longr;
      logic signed [ACC_W-1:0]  accum;
      logic [CNT_W-1:0]         items;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

@@ src/ctk_ram.sv @@
`default_nettype none

module ctk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/ctk_csr.sv @@
`default_nettype none

module ctk_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [ctk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_wdata,
   output ctk_pkg::cfg_type                   cfg
);

   import ctk_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ALPHA:     cfg_in.alpha     = csr_wdata[ALPHA_W-1:0];
            CSR_THRESHOLD: cfg_in.threshold = csr_wdata[9:0];
            CSR_SHORT_MIN: cfg_in.short_min = csr_wdata;
            CSR_SHORT_MAX: cfg_in.short_max = csr_wdata;
            CSR_LONG_TIME: cfg_in.long_time = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha     <= ALPHA_RST;
         cfg_ff.threshold <= THRESHOLD_RST;
         cfg_ff.short_min <= SHORT_MIN_RST;
         cfg_ff.short_max <= SHORT_MAX_RST;
         cfg_ff.long_time <= LONG_TIME_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/cap_touch_key_classifier_top.sv @@
// Touch key classifier.
// Input channel req_*: one item per sample set (op, key, samples, time stamp),
// taken when req_valid is high and req_stall low. Result channel rsp_*: one
// item per input item, in order, held while rsp_stall is high.
// Config channel csr_*: always ready; write only while the block is idle.
// Per-key state sits in a single-port-write, registered-read RAM; the item
// passes five stages (read and filter products, divide by 100, classify,
// calibration divide, touch level) and is written back as it enters the
// output register.
// An accepted item moves through stage registers s1 to s5 and then the
// output register. Key interlock: an item for a key that is still in flight
// waits until that key's write-back (forwarded to the next read), so stages
// s1 to s5 hold at most one item per key; items of the two keys can be in
// flight together.
// Reset clears the configuration to defaults, all pipeline valids and the
// per-key valid and timer bits; an entry never written reads as zero.
// A stalled output register holds; stages behind it keep filling, and input
// is stalled only once stage 1 cannot move or an item of its key is in flight.
`default_nettype none

module cap_touch_key_classifier_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_op,
   input  wire logic                          req_key,
   input  wire logic [9:0]                    req_first_sample,
   input  wire logic [11:0]                   req_second_sum,
   input  wire logic [31:0]                   req_ref_time,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_key_out,
   output logic                               rsp_touched,
   output logic [1:0]                         rsp_event_res,
   output logic                               rsp_short_press,
   output logic                               rsp_long_press,
   output logic                               rsp_held_press,
   output logic [31:0]                        rsp_duration,
   output logic signed [12:0]                 rsp_filtered_delta,
   output logic                               rsp_timer_in_use,
   output logic                               rsp_calibrated,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ctk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_wdata
);

   import ctk_pkg::*;

   typedef struct packed {
      op_type      op;
      logic        key;
      logic [9:0]  first;
      logic [11:0] second;
      logic [31:0] now;
   } item_type;

   typedef struct packed {
      logic   touched;
      ev_type ev;
      logic   sp;
      logic   lp;
      logic   hp;
      logic   tset;
      logic   tclr;
      logic   cal_done;
   } flag_type;

   function automatic logic key_in_range(logic k);
      return int'(k) < KEYS;
   endfunction

   cfg_type cfg;

   ctk_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign csr_ready = 1'b1;

   // pipeline control
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, rsp_vld_ff;
   logic s1_vld_in, s2_vld_in, s3_vld_in, s4_vld_in, s5_vld_in, rsp_vld_in;
   logic out_free, mv1, mv2, mv3, mv4, mv5, free1, free2, free3, free4, free5;
   logic hazard, accept;

   item_type s1_item_ff, s2_item_ff, s3_item_ff, s4_item_ff, s5_item_ff;

   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign mv5   = s5_vld_ff && out_free;
   assign free5 = !s5_vld_ff || mv5;
   assign mv4   = s4_vld_ff && free5;
   assign free4 = !s4_vld_ff || mv4;
   assign mv3   = s3_vld_ff && free4;
   assign free3 = !s3_vld_ff || mv3;
   assign mv2   = s2_vld_ff && free3;
   assign free2 = !s2_vld_ff || mv2;
   assign mv1   = s1_vld_ff && free2;
   assign free1 = !s1_vld_ff || mv1;

   assign hazard = (s1_vld_ff && s1_item_ff.key == req_key)
                || (s2_vld_ff && s2_item_ff.key == req_key)
                || (s3_vld_ff && s3_item_ff.key == req_key)
                || (s4_vld_ff && s4_item_ff.key == req_key)
                || (s5_vld_ff && !mv5 && s5_item_ff.key == req_key);

   assign accept    = req_valid && free1 && !hazard;
   assign req_stall = !free1 || hazard;

   assign s1_vld_in  = accept || (s1_vld_ff && !mv1);
   assign s2_vld_in  = mv1 || (s2_vld_ff && !mv2);
   assign s3_vld_in  = mv2 || (s3_vld_ff && !mv3);
   assign s4_vld_in  = mv3 || (s4_vld_ff && !mv4);
   assign s5_vld_in  = mv4 || (s5_vld_ff && !mv5);
   assign rsp_vld_in = mv5 || (rsp_vld_ff && rsp_stall);

   // state memory
   logic [KEY_AW-1:0]  ram_wr_addr;
   logic               ram_wr_en;
   entry_type          ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [KEYS-1:0]    ent_vld_ff, ent_vld_in;
   logic               byp_hit_ff, byp_hit_in;
   entry_type          byp_data_ff;

   ctk_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEYS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (KEY_AW'(req_key)),
      .rd_data (ram_rd_data)
   );

   assign byp_hit_in = ram_wr_en && (ram_wr_addr == KEY_AW'(req_key));

   always_comb begin
      ent_vld_in = ent_vld_ff;
      if (ram_wr_en) begin
         ent_vld_in[ram_wr_addr] = 1'b1;
      end
   end

   // stage 1: entry select, filter products
   entry_type                e1;
   logic [ALPHA_W-1:0]       alpha_c, alpha_rest;
   logic signed [FILT_W-1:0] delta1;
   logic signed [ACC_W-1:0]  p1_in, p2_in;

   always_comb begin
      if (byp_hit_ff) begin
         e1 = byp_data_ff;
      end else if (ent_vld_ff[KEY_AW'(s1_item_ff.key)]) begin
         e1 = entry_type'(ram_rd_data);
      end else begin
         e1 = '0;
      end
   end

   assign alpha_c    = (cfg.alpha > ALPHA_W'(ALPHA_MAX)) ? ALPHA_W'(ALPHA_MAX) : cfg.alpha;
   assign alpha_rest = ALPHA_W'(ALPHA_MAX) - alpha_c;
   assign delta1     = $signed({3'b000, s1_item_ff.first}) - $signed({1'b0, s1_item_ff.second});
   assign p1_in      = ACC_W'(delta1) * ACC_W'($signed({1'b0, alpha_c}));
   assign p2_in      = ACC_W'(e1.filt) * ACC_W'($signed({1'b0, alpha_rest}));

   // stage 2: sum, divide by 100 through the reciprocal
   logic signed [ACC_W-1:0] s2_p1_ff, s2_p2_ff, sum2;
   entry_type               s2_ent_ff;
   logic [ACC_W-1:0]        mag2;
   logic [FILT_PROD_W-1:0]  fprod_in;

   assign sum2     = s2_p1_ff + s2_p2_ff;
   assign mag2     = sum2[ACC_W-1] ? ACC_W'(-sum2) : ACC_W'(sum2);
   assign fprod_in = FILT_PROD_W'(mag2[FILT_MAG_W-1:0]) * FILT_PROD_W'(FILT_RECIP);

   // stage 3: filtered value, calibration accumulate, touch classification
   logic [FILT_PROD_W-1:0]   s3_fprod_ff;
   logic                     s3_neg_ff;
   entry_type                s3_ent_ff;
   logic [Q_W-1:0]           q3;
   logic signed [FILT_W-1:0] f3;
   logic                     key_ok3, active3, cur3;
   logic [31:0]              d3;
   logic [CNT_W:0]           items_inc3;
   logic signed [ACC_W-1:0]  acc_in;
   entry_type                ent4_in;
   flag_type                 flags4_in;

   assign q3         = Q_W'(s3_fprod_ff >> FILT_SHIFT);
   assign f3         = s3_neg_ff ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
   assign key_ok3    = key_in_range(s3_item_ff.key);
   assign active3    = key_ok3 && (s3_item_ff.op != OP_NONE);
   assign cur3       = s3_ent_ff.cal > CAL_W'(f3);
   assign d3         = s3_item_ff.now - s3_ent_ff.start;
   assign items_inc3 = {1'b0, s3_ent_ff.items} + 1'b1;
   assign acc_in     = s3_ent_ff.accum + ACC_W'(f3);

   always_comb begin
      ent4_in   = s3_ent_ff;
      flags4_in = '0;
      if (active3) begin
         ent4_in.filt = f3;
         case (s3_item_ff.op)
            OP_WARMUP: begin
               ent4_in.accum = '0;
               ent4_in.items = '0;
            end
            OP_ACCUM: begin
               if (items_inc3 >= (CNT_W+1)'(CAL_SAMPLES)) begin
                  ent4_in.accum      = '0;
                  ent4_in.items      = '0;
                  flags4_in.cal_done = 1'b1;
               end else begin
                  ent4_in.accum = acc_in;
                  ent4_in.items = items_inc3[CNT_W-1:0];
               end
            end
            OP_MEASURE: begin
               flags4_in.touched = cur3;
               if (!s3_ent_ff.last && cur3) begin
                  flags4_in.ev   = EV_PRESS;
                  flags4_in.tset = 1'b1;
                  ent4_in.longr  = 1'b0;
                  ent4_in.start  = s3_item_ff.now;
               end else if (s3_ent_ff.last) begin
                  flags4_in.ev = cur3 ? EV_HELD : EV_RELEASE;
                  if (d3 != '0) begin
                     ent4_in.held = d3;
                  end
                  if (!cur3) begin
                     ent4_in.start  = s3_item_ff.now;
                     flags4_in.tclr = 1'b1;
                  end
               end else begin
                  ent4_in.held  = '0;
                  ent4_in.start = '0;
               end
               ent4_in.last = cur3;
               flags4_in.sp = (flags4_in.ev == EV_RELEASE) && (ent4_in.held > cfg.short_min)
                              && (ent4_in.held < cfg.short_max);
               flags4_in.hp = (flags4_in.ev == EV_HELD) && (ent4_in.held > cfg.short_min);
               if (ent4_in.held > cfg.long_time && !ent4_in.longr) begin
                  ent4_in.longr = 1'b1;
                  flags4_in.lp  = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // stage 4: calibration divide through the reciprocal
   entry_type               s4_ent_ff;
   flag_type                s4_flags_ff;
   logic signed [ACC_W-1:0] s4_acc_ff;
   logic [ACC_W-1:0]        mag4;
   logic [CAL_PROD_W-1:0]   cprod_in;

   assign mag4     = s4_acc_ff[ACC_W-1] ? ACC_W'(-s4_acc_ff) : ACC_W'(s4_acc_ff);
   assign cprod_in = CAL_PROD_W'(mag4[CAL_MAG_W-1:0]) * CAL_PROD_W'(CAL_RECIP);

   // stage 5: touch level, write-back, result
   entry_type               s5_ent_ff;
   flag_type                s5_flags_ff;
   logic [CAL_PROD_W-1:0]   s5_cprod_ff;
   logic                    s5_cneg_ff;
   logic [Q_W-1:0]          q5;
   logic signed [CAL_W-1:0] qs5, level5;
   logic                    key_ok5;
   logic [KEYS-1:0]         timing_ff, timing_in;

   assign q5      = Q_W'(s5_cprod_ff >> CAL_SHIFT);
   assign qs5     = s5_cneg_ff ? -$signed({2'b00, q5}) : $signed({2'b00, q5});
   assign level5  = qs5 - $signed({4'b0000, cfg.threshold});
   assign key_ok5 = key_in_range(s5_item_ff.key);

   always_comb begin
      ram_wr_data = s5_ent_ff;
      if (s5_flags_ff.cal_done) begin
         ram_wr_data.cal = level5;
      end
   end

   assign ram_wr_en   = mv5 && key_ok5;
   assign ram_wr_addr = KEY_AW'(s5_item_ff.key);

   always_comb begin
      timing_in = timing_ff;
      if (ram_wr_en && s5_flags_ff.tset) begin
         timing_in[ram_wr_addr] = 1'b1;
      end
      if (ram_wr_en && s5_flags_ff.tclr) begin
         timing_in[ram_wr_addr] = 1'b0;
      end
   end

   // output register
   logic                     rsp_key_ff, rsp_touched_ff, rsp_sp_ff, rsp_lp_ff, rsp_hp_ff;
   logic                     rsp_timer_ff, rsp_cal_ff;
   ev_type                   rsp_ev_ff;
   logic [31:0]              rsp_dur_ff;
   logic signed [FILT_W-1:0] rsp_filt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         ent_vld_ff <= '0;
         timing_ff  <= '0;
         byp_hit_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         s4_vld_ff  <= s4_vld_in;
         s5_vld_ff  <= s5_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         ent_vld_ff <= ent_vld_in;
         timing_ff  <= timing_in;
         if (accept) begin
            byp_hit_ff <= byp_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.op     <= op_type'(req_op);
         s1_item_ff.key    <= req_key;
         s1_item_ff.first  <= req_first_sample;
         s1_item_ff.second <= req_second_sum;
         s1_item_ff.now    <= req_ref_time;
         byp_data_ff       <= ram_wr_data;
      end
      if (mv1) begin
         s2_item_ff <= s1_item_ff;
         s2_ent_ff  <= e1;
         s2_p1_ff   <= p1_in;
         s2_p2_ff   <= p2_in;
      end
      if (mv2) begin
         s3_item_ff  <= s2_item_ff;
         s3_ent_ff   <= s2_ent_ff;
         s3_fprod_ff <= fprod_in;
         s3_neg_ff   <= sum2[ACC_W-1];
      end
      if (mv3) begin
         s4_item_ff  <= s3_item_ff;
         s4_ent_ff   <= ent4_in;
         s4_flags_ff <= flags4_in;
         s4_acc_ff   <= acc_in;
      end
      if (mv4) begin
         s5_item_ff  <= s4_item_ff;
         s5_ent_ff   <= s4_ent_ff;
         s5_flags_ff <= s4_flags_ff;
         s5_cprod_ff <= cprod_in;
         s5_cneg_ff  <= s4_acc_ff[ACC_W-1];
      end
      if (mv5) begin
         rsp_key_ff     <= s5_item_ff.key;
         rsp_touched_ff <= s5_flags_ff.touched;
         rsp_ev_ff      <= s5_flags_ff.ev;
         rsp_sp_ff      <= s5_flags_ff.sp;
         rsp_lp_ff      <= s5_flags_ff.lp;
         rsp_hp_ff      <= s5_flags_ff.hp;
         rsp_dur_ff     <= key_ok5 ? s5_ent_ff.held : '0;
         rsp_filt_ff    <= key_ok5 ? s5_ent_ff.filt : '0;
         rsp_timer_ff   <= |timing_in;
         rsp_cal_ff     <= s5_flags_ff.cal_done;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_key_out        = rsp_key_ff;
   assign rsp_touched        = rsp_touched_ff;
   assign rsp_event_res      = rsp_ev_ff;
   assign rsp_short_press    = rsp_sp_ff;
   assign rsp_long_press     = rsp_lp_ff;
   assign rsp_held_press     = rsp_hp_ff;
   assign rsp_duration       = rsp_dur_ff;
   assign rsp_filtered_delta = rsp_filt_ff;
   assign rsp_timer_in_use   = rsp_timer_ff;
   assign rsp_calibrated     = rsp_cal_ff;

`ifndef SYNTHESIS
   // no write-back while a younger item of the same key is in flight
   a_interlock: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !((s1_vld_ff && s1_item_ff.key == s5_item_ff.key)
                   || (s2_vld_ff && s2_item_ff.key == s5_item_ff.key)
                   || (s3_vld_ff && s3_item_ff.key == s5_item_ff.key)
                   || (s4_vld_ff && s4_item_ff.key == s5_item_ff.key)))
      else $error("state write overlaps an in-flight read of the same key");

   a_head_hold: assert property (@(posedge clock) disable iff (reset)
      (s5_vld_ff && !out_free) |=> (s5_vld_ff && $stable(s5_item_ff)))
      else $error("head stage lost its item under stall");

   a_cal_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_cal_ff) |-> (!rsp_touched_ff && rsp_ev_ff == EV_NONE))
      else $error("calibration item reported touch activity");

   a_short_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_sp_ff) |-> (rsp_ev_ff == EV_RELEASE))
      else $error("short press without release edge");
`endif

endmodule

`default_nettype wire

@@ tb/touch_report_checker.sv @@
`timescale 1ns / 100ps

module touch_report_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [1:0]                    req_op,
   input  wire logic                          req_key,
   input  wire logic [9:0]                    req_first_sample,
   input  wire logic [11:0]                   req_second_sum,
   input  wire logic [31:0]                   req_ref_time,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic                          rsp_key_out,
   input  wire logic                          rsp_touched,
   input  wire logic [1:0]                    rsp_event_res,
   input  wire logic                          rsp_short_press,
   input  wire logic                          rsp_long_press,
   input  wire logic                          rsp_held_press,
   input  wire logic [31:0]                   rsp_duration,
   input  wire logic [12:0]                   rsp_filtered_delta,
   input  wire logic                          rsp_timer_in_use,
   input  wire logic                          rsp_calibrated,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [ctk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_wdata,
   output int                                 mismatches,
   output int                                 outstanding
);

   import ctk_pkg::*;

   typedef struct packed {
      logic              key;
      logic              touched;
      ev_type            ev;
      logic              short_p;
      logic              long_p;
      logic              held_p;
      logic [31:0]       dur;
      logic [FILT_W-1:0] filt;
      logic              timer;
      logic              cal;
   } touch_report_type;

   touch_report_type expected_reports[$];

   logic [ALPHA_W-1:0] alpha_r;
   logic [9:0]         thresh_r;
   logic [31:0]        smin_r;
   logic [31:0]        smax_r;
   logic [31:0]        long_r;

   int          filt_q   [KEYS];
   int          level_q  [KEYS];
   bit          last_q   [KEYS];
   logic [31:0] start_q  [KEYS];
   logic [31:0] held_q   [KEYS];
   bit          longr_q  [KEYS];
   bit          timing_q [KEYS];
   int          accum_q  [KEYS];
   int          items_q  [KEYS];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic touch_report_type classify_sample(op_type op, logic key, logic [9:0] fs,
                                                        logic [11:0] ss, logic [31:0] now);
      int               a;
      int               delta;
      int               f;
      bit               cur;
      bit               prev;
      logic [31:0]      d;
      touch_report_type r;
      r = '0;
      r.key = key;
      if (op != OP_NONE) begin
         a = (alpha_r > ALPHA_MAX) ? ALPHA_MAX : int'(alpha_r);
         delta = int'(fs) - int'(ss);
         f = (delta * a + (ALPHA_MAX - a) * filt_q[key]) / ALPHA_MAX;
         filt_q[key] = f;
         if (op == OP_WARMUP) begin
            accum_q[key] = 0;
            items_q[key] = 0;
         end else if (op == OP_ACCUM) begin
            accum_q[key] += f;
            items_q[key]++;
            if (items_q[key] >= CAL_SAMPLES) begin
               level_q[key] = accum_q[key] / CAL_SAMPLES - int'(thresh_r);
               accum_q[key] = 0;
               items_q[key] = 0;
               r.cal = 1'b1;
            end
         end else begin
            cur = level_q[key] > f;
            prev = last_q[key];
            r.touched = cur;
            if (!prev && cur) begin
               r.ev = EV_PRESS;
               longr_q[key] = 1'b0;
               timing_q[key] = 1'b1;
               start_q[key] = now;
            end else if (prev) begin
               d = now - start_q[key];
               if (cur) begin
                  r.ev = EV_HELD;
               end else begin
                  r.ev = EV_RELEASE;
               end
               if (d != 0) held_q[key] = d;
               if (!cur) begin
                  start_q[key] = now;
                  timing_q[key] = 1'b0;
               end
            end else begin
               held_q[key] = '0;
               start_q[key] = '0;
            end
            last_q[key] = cur;
            if (r.ev == EV_RELEASE && held_q[key] > smin_r && held_q[key] < smax_r)
               r.short_p = 1'b1;
            if (r.ev == EV_HELD && held_q[key] > smin_r) r.held_p = 1'b1;
            if (held_q[key] > long_r && !longr_q[key]) begin
               longr_q[key] = 1'b1;
               r.long_p = 1'b1;
            end
         end
      end
      r.dur = held_q[key];
      r.filt = filt_q[key][FILT_W-1:0];
      for (int i = 0; i < KEYS; i++) begin
         if (timing_q[i]) r.timer = 1'b1;
      end
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      touch_report_type want;
      if (reset) begin
         alpha_r  = ALPHA_RST;
         thresh_r = THRESHOLD_RST;
         smin_r   = SHORT_MIN_RST;
         smax_r   = SHORT_MAX_RST;
         long_r   = LONG_TIME_RST;
         for (int i = 0; i < KEYS; i++) begin
            filt_q[i]   = 0;
            level_q[i]  = 0;
            last_q[i]   = 1'b0;
            start_q[i]  = '0;
            held_q[i]   = '0;
            longr_q[i]  = 1'b0;
            timing_q[i] = 1'b0;
            accum_q[i]  = 0;
            items_q[i]  = 0;
         end
         expected_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ALPHA:     alpha_r  = csr_wdata[ALPHA_W-1:0];
               CSR_THRESHOLD: thresh_r = csr_wdata[9:0];
               CSR_SHORT_MIN: smin_r   = csr_wdata;
               CSR_SHORT_MAX: smax_r   = csr_wdata;
               CSR_LONG_TIME: long_r   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual key %0d",
                        $time, rsp_key_out);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               check_field("key_out", 32'(want.key), 32'(rsp_key_out));
               check_field("touched", 32'(want.touched), 32'(rsp_touched));
               check_field("event_res", 32'(want.ev), 32'(rsp_event_res));
               check_field("short_press", 32'(want.short_p), 32'(rsp_short_press));
               check_field("long_press", 32'(want.long_p), 32'(rsp_long_press));
               check_field("held_press", 32'(want.held_p), 32'(rsp_held_press));
               check_field("duration", want.dur, rsp_duration);
               check_field("filtered_delta", 32'(want.filt), 32'(rsp_filtered_delta));
               check_field("timer_in_use", 32'(want.timer), 32'(rsp_timer_in_use));
               check_field("calibrated", 32'(want.cal), 32'(rsp_calibrated));
            end
         end
         if (req_valid && !req_stall)
            expected_reports.push_back(classify_sample(op_type'(req_op), req_key,
                                                       req_first_sample, req_second_sum,
                                                       req_ref_time));
      end
      outstanding = expected_reports.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

   import ctk_pkg::*;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic [1:0]           req_op           = '0;
   logic                 req_key          = 1'b0;
   logic [9:0]           req_first_sample = '0;
   logic [11:0]          req_second_sum   = '0;
   logic [31:0]          req_ref_time     = '0;
   logic                 rsp_stall        = 1'b0;
   logic                 csr_valid        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [31:0]          csr_wdata        = '0;

   wire logic        req_stall;
   wire logic        rsp_valid;
   wire logic        rsp_key_out;
   wire logic        rsp_touched;
   wire logic [1:0]  rsp_event_res;
   wire logic        rsp_short_press;
   wire logic        rsp_long_press;
   wire logic        rsp_held_press;
   wire logic [31:0] rsp_duration;
   wire logic [12:0] rsp_filtered_delta;
   wire logic        rsp_timer_in_use;
   wire logic        rsp_calibrated;
   wire logic        csr_ready;

   int errors;
   int pending;

   bit          idle_on = 1'b1;
   bit          press_mode [KEYS];
   logic [31:0] key_clock  [KEYS];

   always #5 clock = ~clock;

   cap_touch_key_classifier_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_key            (req_key),
      .req_first_sample   (req_first_sample),
      .req_second_sum     (req_second_sum),
      .req_ref_time       (req_ref_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key_out        (rsp_key_out),
      .rsp_touched        (rsp_touched),
      .rsp_event_res      (rsp_event_res),
      .rsp_short_press    (rsp_short_press),
      .rsp_long_press     (rsp_long_press),
      .rsp_held_press     (rsp_held_press),
      .rsp_duration       (rsp_duration),
      .rsp_filtered_delta (rsp_filtered_delta),
      .rsp_timer_in_use   (rsp_timer_in_use),
      .rsp_calibrated     (rsp_calibrated),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   touch_report_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_key            (req_key),
      .req_first_sample   (req_first_sample),
      .req_second_sum     (req_second_sum),
      .req_ref_time       (req_ref_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_key_out        (rsp_key_out),
      .rsp_touched        (rsp_touched),
      .rsp_event_res      (rsp_event_res),
      .rsp_short_press    (rsp_short_press),
      .rsp_long_press     (rsp_long_press),
      .rsp_held_press     (rsp_held_press),
      .rsp_duration       (rsp_duration),
      .rsp_filtered_delta (rsp_filtered_delta),
      .rsp_timer_in_use   (rsp_timer_in_use),
      .rsp_calibrated     (rsp_calibrated),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatches         (errors),
      .outstanding        (pending)
   );

   initial begin
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 3)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // block idle: nothing in flight, then allow for pipeline latency
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic send_item(input op_type op, input logic key, input logic [9:0] fs,
                            input logic [11:0] ss, input logic [31:0] stamp);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_op           = op;
      req_key          = key;
      req_first_sample = fs;
      req_second_sum   = ss;
      req_ref_time     = stamp;
      do @(posedge clock); while (req_stall);
   endtask

   // mostly measure runs alternating between pressed and released samples
   task automatic random_item(input logic key);
      int          c;
      op_type      op;
      logic [9:0]  fs;
      logic [11:0] ss;
      c = $urandom_range(0, 99);
      if (c < 8) begin
         send_item(op_type'($urandom_range(0, 3)), key, 10'($urandom_range(0, 1023)),
                   12'($urandom_range(0, 3069)), $urandom);
      end else begin
         if ($urandom_range(0, 99) < 15) press_mode[key] = ~press_mode[key];
         c = $urandom_range(0, 99);
         if (c < 10) begin
         end else if (c < 14) begin
            key_clock[key] += $urandom;
         end else begin
            key_clock[key] += $urandom_range(1, 12);
         end
         if (press_mode[key]) begin
            fs = 10'($urandom_range(0, 200));
            ss = 12'($urandom_range(2500, 3069));
         end else begin
            fs = 10'($urandom_range(800, 1023));
            ss = 12'($urandom_range(0, 300));
         end
         c = $urandom_range(0, 99);
         if (c < 90) begin
            op = OP_MEASURE;
         end else if (c < 95) begin
            op = OP_WARMUP;
         end else begin
            op = OP_ACCUM;
         end
         send_item(op, key, fs, ss, key_clock[key]);
      end
   endtask

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) random_item(1'($urandom_range(0, 1)));
   endtask

   // all keys calibrated together, items of the keys interleaved
   task automatic calibrate();
      for (int k = 0; k < KEYS; k++)
         send_item(OP_WARMUP, 1'(k), 10'($urandom_range(600, 1023)),
                   12'($urandom_range(0, 400)), $urandom);
      for (int i = 0; i < CAL_SAMPLES; i++) begin
         for (int k = 0; k < KEYS; k++) begin
            if ($urandom_range(0, 19) == 0)
               send_item(OP_MEASURE, 1'(k), 10'($urandom_range(0, 1023)),
                         12'($urandom_range(0, 3069)), $urandom);
            send_item(OP_ACCUM, 1'(k), 10'($urandom_range(600, 1023)),
                      12'($urandom_range(0, 400)), $urandom);
         end
      end
   endtask

   task automatic load_config(input logic [31:0] alpha, input logic [31:0] thresh,
                              input logic [31:0] smin, input logic [31:0] smax,
                              input logic [31:0] long_t);
      write_reg(CSR_ALPHA, alpha);
      write_reg(CSR_THRESHOLD, thresh);
      write_reg(CSR_SHORT_MIN, smin);
      write_reg(CSR_SHORT_MAX, smax);
      write_reg(CSR_LONG_TIME, long_t);
   endtask

   initial begin
      for (int i = 0; i < KEYS; i++) begin
         press_mode[i] = 1'b0;
         key_clock[i]  = $urandom;
      end
      repeat (12) @(negedge clock);
      reset = 1'b0;

      send_item(OP_MEASURE, 1'b0, 10'd0, 12'd0, 32'd0);
      send_item(OP_MEASURE, 1'b0, 10'd1023, 12'd0, 32'd1);
      send_item(OP_MEASURE, 1'b0, 10'd0, 12'd3069, 32'd5);
      send_item(OP_MEASURE, 1'b0, 10'd0, 12'd3069, 32'd5);
      send_item(OP_MEASURE, 1'b0, 10'd0, 12'd3069, 32'd10);
      send_item(OP_MEASURE, 1'b0, 10'd0, 12'd3069, 32'd60);
      send_item(OP_MEASURE, 1'b0, 10'd0, 12'd3069, 32'd70);
      send_item(OP_MEASURE, 1'b0, 10'd1023, 12'd0, 32'd75);
      send_item(OP_MEASURE, 1'b0, 10'd1023, 12'd0, 32'd80);
      send_item(OP_MEASURE, 1'b1, 10'd0, 12'd3069, 32'd100);
      send_item(OP_MEASURE, 1'b1, 10'd1023, 12'd0, 32'd110);
      send_item(OP_MEASURE, 1'b1, 10'd0, 12'd3069, 32'hFFFF_FFF0);
      send_item(OP_MEASURE, 1'b1, 10'd1023, 12'd0, 32'h0000_0005);
      send_item(OP_NONE, 1'b0, 10'h3FF, 12'hBFD, 32'hFFFF_FFFF);
      send_item(OP_NONE, 1'b1, 10'h000, 12'h000, 32'h0000_0000);
      send_item(OP_WARMUP, 1'b0, 10'd512, 12'd1024, 32'hAAAA_5555);
      send_item(OP_ACCUM, 1'b0, 10'd1023, 12'd3069, 32'h5555_AAAA);
      send_item(OP_ACCUM, 1'b1, 10'd0, 12'd0, 32'h1234_5678);
      send_item(OP_MEASURE, 1'b0, 10'h2AA, 12'h555, 32'h5555_AAAA);
      send_item(OP_MEASURE, 1'b1, 10'h155, 12'hAAA, 32'hAAAA_5555);
      drain();

      load_config(32'd100, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(25);
      drain();
      run_random(20);
      drain();

      load_config(32'd0, 32'd1023, 32'hFFFF_FFFF, 32'd0, 32'd0);
      run_random(20);
      drain();

      for (int i = int'(CSR_LONG_TIME) + 1; i < (1 << CSR_IDX_W); i++)
         write_reg(CSR_IDX_W'(i), $urandom);
      load_config(32'hFFFF_FF7F, 32'd512, 32'd3, 32'd15, 32'd25);
      calibrate();
      run_random(20);
      drain();

      load_config(32'd35, 32'd20, 32'd1, 32'd20, 32'd40);
      run_random(15);
      idle_on = 1'b0;
      run_random(15);
      drain();

      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
